// ===== design/rrp_pkg.sv =====
package rrp_pkg;

    // Default sizing
    localparam int MAX_LINE_DEF = 255;
    localparam int LEN_BITS_DEF = 32;

    // Field widths fixed by the result format
    localparam int KIND_W   = 4;
    localparam int BYTE_W   = 8;
    localparam int HDR_W    = 8;
    localparam int BLEN_W   = 32;

    // Characters of the protocol
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        K_SIMPLE   = 4'd0,
        K_INTEGER  = 4'd1,
        K_BULK     = 4'd2,
        K_NULL     = 4'd3,
        K_ERRREPLY = 4'd4,
        K_BADTYPE  = 4'd5,
        K_BADEND   = 4'd6,
        K_TOOLONG  = 4'd7,
        K_BADLEN   = 4'd8
    } kind_t;

    // Length parser stages
    typedef enum logic [1:0] {
        NS_SPACE  = 2'd0,
        NS_SIGN   = 2'd1,
        NS_DIGITS = 2'd2,
        NS_DONE   = 2'd3
    } num_stage_t;

    // Length parser control state
    typedef struct packed {
        num_stage_t stage;
        logic       neg;
        logic       ovf;
    } num_ctl_t;

endpackage

// ===== design/resp_reply_parser.sv =====
// Reply parser for a RESP2 byte stream.
//
// Input channel rx: one received byte per beat on rx_byte, handshake
// rx_valid / rx_stall. Output channel reply: one beat per finished or
// failed reply, carrying reply_kind, type_code, header_chars and
// bulk_length, handshake reply_valid / reply_stall.
//
// Throughput: one byte per cycle, sustained, as long as reply_stall stays
// low. Every byte is handled by a single pass through the parse logic that
// sits between the byte register and the result register.
// Path: the byte that completes a reply goes from the byte register into
// the result register, when that is free, which drives reply_valid.
//
// Reset (rst_n low) empties both registers and leaves the parser waiting
// for a type byte. While reply_stall holds a result, the byte register
// fills and then rx_stall rises until the result is taken; nothing is
// dropped. A bulk reply consumes its payload plus two unchecked trailing
// bytes, meant as CR LF, before its beat appears.
module resp_reply_parser #(
    parameter int MAX_LINE = rrp_pkg::MAX_LINE_DEF,
    parameter int LEN_BITS = rrp_pkg::LEN_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        rx_valid,
    output logic                        rx_stall,
    input  logic [rrp_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        reply_valid,
    input  logic                        reply_stall,
    output logic [rrp_pkg::KIND_W-1:0]  reply_kind,
    output logic [rrp_pkg::BYTE_W-1:0]  type_code,
    output logic [rrp_pkg::HDR_W-1:0]   header_chars,
    output logic [rrp_pkg::BLEN_W-1:0]  bulk_length
);

    logic                       byte_valid_reg, byte_valid_next;
    logic [rrp_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                       byte_take;

    // Stall only when the held byte cannot move on
    assign rx_stall = byte_valid_reg && !byte_take;

    // Load the byte register on each accepted beat
    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        byte_next       = byte_reg;
        if (!rx_stall)
        begin
            byte_valid_next = rx_valid;
            if (rx_valid)
            begin
                byte_next = rx_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            byte_reg       <= '0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            byte_reg       <= byte_next;
        end
    end

    rrp_fsm #(
        .MAX_LINE (MAX_LINE),
        .LEN_BITS (LEN_BITS)
    ) u_fsm (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid_reg),
        .byte_data    (byte_reg),
        .byte_take    (byte_take),
        .reply_valid  (reply_valid),
        .reply_stall  (reply_stall),
        .reply_kind   (reply_kind),
        .type_code    (type_code),
        .header_chars (header_chars),
        .bulk_length  (bulk_length)
    );

endmodule

// ===== design/rrp_num.sv =====
module rrp_num #(
    parameter int LEN_BITS = rrp_pkg::LEN_BITS_DEF
) (
    input  logic [7:0]          ch,
    input  rrp_pkg::num_ctl_t   ctl_cur,
    input  logic [LEN_BITS-1:0] accum_cur,
    output rrp_pkg::num_ctl_t   ctl_nxt,
    output logic [LEN_BITS-1:0] accum_nxt
);

    localparam int SW = LEN_BITS + 4;

    logic          is_digit;
    logic          is_blank;
    logic          take_char;
    logic [SW-1:0] scaled;
    logic [3:0]    digit_val;

    assign is_digit  = (ch >= rrp_pkg::CH_ZERO) && (ch <= rrp_pkg::CH_NINE);
    assign is_blank  = (ch == rrp_pkg::CH_SPACE) || (ch == rrp_pkg::CH_TAB)
                    || (ch == rrp_pkg::CH_LF) || (ch == rrp_pkg::CH_VT)
                    || (ch == rrp_pkg::CH_FF) || (ch == rrp_pkg::CH_CR);
    assign digit_val = 4'(ch - rrp_pkg::CH_ZERO);

    // Times ten plus digit, with four spare bits to see overflow
    assign scaled = (SW'(accum_cur) << 3) + (SW'(accum_cur) << 1) + SW'(digit_val);

    // Step the strtol-style reader by one character
    always_comb
    begin
        ctl_nxt   = ctl_cur;
        accum_nxt = accum_cur;
        take_char = 1'b0;
        case (ctl_cur.stage)
            rrp_pkg::NS_SPACE:
            begin
                if (is_blank)
                begin
                    take_char = 1'b0;
                end
                else if ((ch == rrp_pkg::CH_PLUS) || (ch == rrp_pkg::CH_MINUS))
                begin
                    ctl_nxt.neg   = (ch == rrp_pkg::CH_MINUS);
                    ctl_nxt.stage = rrp_pkg::NS_SIGN;
                end
                else
                begin
                    take_char = 1'b1;
                end
            end
            rrp_pkg::NS_SIGN,
            rrp_pkg::NS_DIGITS:
            begin
                take_char = 1'b1;
            end
            default:
            begin
                take_char = 1'b0;
            end
        endcase

        if (take_char)
        begin
            if (!is_digit)
            begin
                ctl_nxt.stage = rrp_pkg::NS_DONE;
            end
            else
            begin
                ctl_nxt.stage = rrp_pkg::NS_DIGITS;
                if (!ctl_cur.ovf)
                begin
                    if (|scaled[SW-1:LEN_BITS])
                    begin
                        ctl_nxt.ovf = 1'b1;
                    end
                    else
                    begin
                        accum_nxt = scaled[LEN_BITS-1:0];
                    end
                end
            end
        end
    end

endmodule

// ===== design/rrp_fsm.sv =====
module rrp_fsm #(
    parameter int MAX_LINE = rrp_pkg::MAX_LINE_DEF,
    parameter int LEN_BITS = rrp_pkg::LEN_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        byte_valid,
    input  logic [rrp_pkg::BYTE_W-1:0]  byte_data,
    output logic                        byte_take,
    output logic                        reply_valid,
    input  logic                        reply_stall,
    output logic [rrp_pkg::KIND_W-1:0]  reply_kind,
    output logic [rrp_pkg::BYTE_W-1:0]  type_code,
    output logic [rrp_pkg::HDR_W-1:0]   header_chars,
    output logic [rrp_pkg::BLEN_W-1:0]  bulk_length
);

    localparam int CW = $clog2(MAX_LINE + 1);
    localparam int HW = (CW > rrp_pkg::HDR_W) ? CW : rrp_pkg::HDR_W;
    localparam int DW = LEN_BITS + 1;
    localparam int XW = LEN_BITS + rrp_pkg::BLEN_W;

    typedef enum logic [1:0] {
        PH_TYPE    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_LF      = 2'd2,
        PH_DISCARD = 2'd3
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic [7:0]                   rtype_reg, rtype_next;
    logic [CW-1:0]                count_reg, count_next;
    rrp_pkg::num_ctl_t            ctl_reg, ctl_next, ctl_num;
    logic [LEN_BITS-1:0]          accum_reg, accum_next, accum_num;
    logic [DW-1:0]                disc_reg, disc_next;

    logic                         out_valid_reg, out_valid_next;
    rrp_pkg::kind_t               kind_reg, kind_next;
    logic [7:0]                   tcode_reg, tcode_next;
    logic [rrp_pkg::HDR_W-1:0]    hdr_reg, hdr_next;
    logic [rrp_pkg::BLEN_W-1:0]   blen_reg, blen_next;

    logic                         step;
    logic                         emit;
    rrp_pkg::kind_t               emit_kind;
    logic                         emit_bulk;
    logic [HW-1:0]                count_ext;
    logic [XW-1:0]                accum_ext;

    rrp_num #(
        .LEN_BITS (LEN_BITS)
    ) u_num (
        .ch        (byte_data),
        .ctl_cur   (ctl_reg),
        .accum_cur (accum_reg),
        .ctl_nxt   (ctl_num),
        .accum_nxt (accum_num)
    );

    // Process a byte whenever the result register is free or being drained
    assign byte_take = !out_valid_reg || !reply_stall;
    assign step      = byte_valid && byte_take;

    assign count_ext = HW'(count_reg);
    assign accum_ext = XW'(accum_reg);

    // Advance the reply state by one byte
    always_comb
    begin
        phase_next = phase_reg;
        rtype_next = rtype_reg;
        count_next = count_reg;
        ctl_next   = ctl_reg;
        accum_next = accum_reg;
        disc_next  = disc_reg;
        emit       = 1'b0;
        emit_kind  = rrp_pkg::K_SIMPLE;
        emit_bulk  = 1'b0;
        if (step)
        begin
            case (phase_reg)
                PH_TYPE:
                begin
                    rtype_next = byte_data;
                    count_next = '0;
                    ctl_next   = '{stage: rrp_pkg::NS_SPACE, neg: 1'b0, ovf: 1'b0};
                    accum_next = '0;
                    disc_next  = '0;
                    phase_next = PH_HEADER;
                end
                PH_HEADER:
                begin
                    if (byte_data == rrp_pkg::CH_CR)
                    begin
                        phase_next = PH_LF;
                    end
                    else if (count_reg >= CW'(MAX_LINE))
                    begin
                        emit      = 1'b1;
                        emit_kind = rrp_pkg::K_TOOLONG;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                        if (rtype_reg == rrp_pkg::CH_DOLLAR)
                        begin
                            ctl_next   = ctl_num;
                            accum_next = accum_num;
                        end
                    end
                end
                PH_LF:
                begin
                    if (byte_data != rrp_pkg::CH_LF)
                    begin
                        emit      = 1'b1;
                        emit_kind = rrp_pkg::K_BADEND;
                    end
                    else if (rtype_reg == rrp_pkg::CH_PLUS)
                    begin
                        emit      = 1'b1;
                        emit_kind = rrp_pkg::K_SIMPLE;
                    end
                    else if (rtype_reg == rrp_pkg::CH_COLON)
                    begin
                        emit      = 1'b1;
                        emit_kind = rrp_pkg::K_INTEGER;
                    end
                    else if (rtype_reg == rrp_pkg::CH_MINUS)
                    begin
                        emit      = 1'b1;
                        emit_kind = rrp_pkg::K_ERRREPLY;
                    end
                    else if (rtype_reg == rrp_pkg::CH_DOLLAR)
                    begin
                        if (ctl_reg.ovf)
                        begin
                            emit      = 1'b1;
                            emit_kind = rrp_pkg::K_BADLEN;
                        end
                        else if (ctl_reg.neg && (accum_reg == LEN_BITS'(1)))
                        begin
                            emit      = 1'b1;
                            emit_kind = rrp_pkg::K_NULL;
                        end
                        else if (ctl_reg.neg && (accum_reg > LEN_BITS'(1)))
                        begin
                            emit      = 1'b1;
                            emit_kind = rrp_pkg::K_BADLEN;
                        end
                        else
                        begin
                            disc_next  = DW'(accum_reg) + DW'(2);
                            phase_next = PH_DISCARD;
                        end
                    end
                    else
                    begin
                        emit      = 1'b1;
                        emit_kind = rrp_pkg::K_BADTYPE;
                    end
                end
                PH_DISCARD:
                begin
                    disc_next = disc_reg - DW'(1);
                    if (disc_reg == DW'(1))
                    begin
                        emit      = 1'b1;
                        emit_kind = rrp_pkg::K_BULK;
                        emit_bulk = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_TYPE;
                end
            endcase
            if (emit)
            begin
                phase_next = PH_TYPE;
            end
        end
    end

    // Load the result register on a finished reply, drop it when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        kind_next      = kind_reg;
        tcode_next     = tcode_reg;
        hdr_next       = hdr_reg;
        blen_next      = blen_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            kind_next      = emit_kind;
            tcode_next     = rtype_reg;
            hdr_next       = (count_ext > HW'(255)) ? 8'hFF : count_ext[7:0];
            blen_next      = emit_bulk ? accum_ext[rrp_pkg::BLEN_W-1:0] : '0;
        end
        else if (out_valid_reg && !reply_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_TYPE;
            rtype_reg     <= '0;
            count_reg     <= '0;
            ctl_reg       <= '{stage: rrp_pkg::NS_SPACE, neg: 1'b0, ovf: 1'b0};
            accum_reg     <= '0;
            disc_reg      <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= rrp_pkg::K_SIMPLE;
            tcode_reg     <= '0;
            hdr_reg       <= '0;
            blen_reg      <= '0;
        end
        else
        begin
            phase_reg     <= phase_next;
            rtype_reg     <= rtype_next;
            count_reg     <= count_next;
            ctl_reg       <= ctl_next;
            accum_reg     <= accum_next;
            disc_reg      <= disc_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            tcode_reg     <= tcode_next;
            hdr_reg       <= hdr_next;
            blen_reg      <= blen_next;
        end
    end

    assign reply_valid  = out_valid_reg;
    assign reply_kind   = kind_reg;
    assign type_code    = tcode_reg;
    assign header_chars = hdr_reg;
    assign bulk_length  = blen_reg;

endmodule

// ===== design/rrp_checker.sv =====
module rrp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        reply_valid,
    input logic                        reply_stall,
    input logic [rrp_pkg::KIND_W-1:0]  reply_kind,
    input logic [rrp_pkg::BYTE_W-1:0]  type_code,
    input logic [rrp_pkg::BLEN_W-1:0]  bulk_length
);

    // A stalled reply beat holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && reply_stall |=> reply_valid && $stable(reply_kind)
            && $stable(type_code) && $stable(bulk_length))
        else $error("reply beat changed while stalled");

    // Kind stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid |-> reply_kind <= rrp_pkg::K_BADLEN)
        else $error("reply kind out of range");

    // Only a bulk reply carries a length
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && (reply_kind != rrp_pkg::K_BULK) |-> bulk_length == '0)
        else $error("length on a non-bulk reply");

    // Bulk, null bulk and bad-length replies come from a dollar type byte
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && ((reply_kind == rrp_pkg::K_BULK) || (reply_kind == rrp_pkg::K_NULL)
            || (reply_kind == rrp_pkg::K_BADLEN))
        |-> type_code == rrp_pkg::CH_DOLLAR)
        else $error("bulk result with wrong type byte");

    // A simple reply matches its plus type byte
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && (reply_kind == rrp_pkg::K_SIMPLE) |-> type_code == rrp_pkg::CH_PLUS)
        else $error("simple reply with wrong type byte");

endmodule

bind resp_reply_parser rrp_checker u_rrp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .reply_valid (reply_valid),
    .reply_stall (reply_stall),
    .reply_kind  (reply_kind),
    .type_code   (type_code),
    .bulk_length (bulk_length)
);

// ===== bench/resp_reply_parser_tb.sv =====
module resp_reply_parser_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;

    typedef enum logic [1:0] {
        PARSE_TYPE,
        PARSE_HEADER,
        PARSE_LF,
        PARSE_DISCARD
    } parse_phase_t;

    typedef struct {
        rrp_pkg::kind_t             kind;
        logic [rrp_pkg::BYTE_W-1:0] type_code;
        logic [rrp_pkg::HDR_W-1:0]  hdr;
        logic [rrp_pkg::BLEN_W-1:0] blen;
    } reply_beat_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       rx_valid;
    logic                       rx_stall;
    logic [rrp_pkg::BYTE_W-1:0] rx_byte;
    logic                       reply_valid;
    logic                       reply_stall = 1'b0;
    logic [rrp_pkg::KIND_W-1:0] reply_kind;
    logic [rrp_pkg::BYTE_W-1:0] type_code;
    logic [rrp_pkg::HDR_W-1:0]  header_chars;
    logic [rrp_pkg::BLEN_W-1:0] bulk_length;

    // Replies still owed by the parser, oldest first
    reply_beat_t pending_replies[$];

    int rx_gap_pct = 35;
    int reply_gap_pct = 78;
    int bytes_sent = 0;
    int error_count = 0;
    int cycle_count = 0;

    // Shadow parser state
    parse_phase_t         prs_phase = PARSE_TYPE;
    logic [7:0]           prs_type = 8'd0;
    int                   prs_chars = 0;
    rrp_pkg::num_stage_t  prs_stage = rrp_pkg::NS_SPACE;
    logic                 prs_neg = 1'b0;
    logic                 prs_ovf = 1'b0;
    logic [63:0]          prs_len = 64'd0;
    logic [63:0]          prs_left = 64'd0;

    resp_reply_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_stall     (rx_stall),
        .rx_byte      (rx_byte),
        .reply_valid  (reply_valid),
        .reply_stall  (reply_stall),
        .reply_kind   (reply_kind),
        .type_code    (type_code),
        .header_chars (header_chars),
        .bulk_length  (bulk_length)
    );

    always #2 clk = ~clk;

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("resp_reply_parser verification failed");
            $finish;
        end
    end

    // Stall the reply channel at random
    always @(negedge clk)
    begin
        reply_stall <= ($urandom_range(0, 99) < reply_gap_pct);
    end

    // Compare each reply beat with the oldest expected reply
    always @(posedge clk)
    begin : check_replies
        reply_beat_t want;
        if (rst_n && reply_valid && !reply_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("reply beat with none expected: reply_kind %0d type_code %0d",
                       reply_kind, type_code);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (reply_kind !== want.kind)
                begin
                    $error("reply_kind: expected %0d, got %0d", want.kind, reply_kind);
                    error_count++;
                end
                if (type_code !== want.type_code)
                begin
                    $error("type_code: expected %0d, got %0d", want.type_code, type_code);
                    error_count++;
                end
                if (header_chars !== want.hdr)
                begin
                    $error("header_chars: expected %0d, got %0d", want.hdr, header_chars);
                    error_count++;
                end
                if (bulk_length !== want.blen)
                begin
                    $error("bulk_length: expected %0d, got %0d", want.blen, bulk_length);
                    error_count++;
                end
            end
        end
    end

    // Queue a finished reply and wait for the next type byte
    function automatic void finish_reply(rrp_pkg::kind_t kind,
                                         logic [rrp_pkg::BLEN_W-1:0] blen);
        reply_beat_t r;
        r.kind = kind;
        r.type_code = prs_type;
        r.hdr = (prs_chars > 255) ? 8'd255 : 8'(prs_chars);
        r.blen = blen;
        pending_replies.push_back(r);
        prs_phase = PARSE_TYPE;
    endfunction

    // Fold one header character into the bulk length, strtol style
    function automatic void take_length_char(logic [7:0] c);
        logic        is_digit;
        logic        is_blank;
        logic [63:0] d;
        logic [63:0] len_max;
        is_digit = (c >= rrp_pkg::CH_ZERO) && (c <= rrp_pkg::CH_NINE);
        is_blank = (c == rrp_pkg::CH_SPACE) || (c == rrp_pkg::CH_TAB) ||
                   (c == rrp_pkg::CH_LF) || (c == rrp_pkg::CH_VT) ||
                   (c == rrp_pkg::CH_FF) || (c == rrp_pkg::CH_CR);
        len_max = (64'd1 << rrp_pkg::LEN_BITS_DEF) - 64'd1;
        if (prs_stage == rrp_pkg::NS_DONE)
            return;
        if (prs_stage == rrp_pkg::NS_SPACE)
        begin
            if (is_blank)
                return;
            if (c == rrp_pkg::CH_PLUS || c == rrp_pkg::CH_MINUS)
            begin
                prs_neg = (c == rrp_pkg::CH_MINUS);
                prs_stage = rrp_pkg::NS_SIGN;
                return;
            end
        end
        if (!is_digit)
        begin
            prs_stage = rrp_pkg::NS_DONE;
            return;
        end
        prs_stage = rrp_pkg::NS_DIGITS;
        if (!prs_ovf)
        begin
            d = {56'd0, c - rrp_pkg::CH_ZERO};
            if (prs_len > (len_max - d) / 64'd10)
                prs_ovf = 1'b1;
            else
                prs_len = prs_len * 64'd10 + d;
        end
    endfunction

    // Advance the shadow parser by one accepted byte
    function automatic void parse_byte(logic [7:0] c);
        case (prs_phase)
            PARSE_TYPE:
            begin
                prs_type = c;
                prs_chars = 0;
                prs_stage = rrp_pkg::NS_SPACE;
                prs_neg = 1'b0;
                prs_ovf = 1'b0;
                prs_len = 64'd0;
                prs_left = 64'd0;
                prs_phase = PARSE_HEADER;
            end
            PARSE_HEADER:
            begin
                if (c == rrp_pkg::CH_CR)
                    prs_phase = PARSE_LF;
                else if (prs_chars >= rrp_pkg::MAX_LINE_DEF)
                    finish_reply(rrp_pkg::K_TOOLONG, '0);
                else
                begin
                    prs_chars++;
                    if (prs_type == rrp_pkg::CH_DOLLAR)
                        take_length_char(c);
                end
            end
            PARSE_LF:
            begin
                if (c != rrp_pkg::CH_LF)
                    finish_reply(rrp_pkg::K_BADEND, '0);
                else if (prs_type == rrp_pkg::CH_PLUS)
                    finish_reply(rrp_pkg::K_SIMPLE, '0);
                else if (prs_type == rrp_pkg::CH_COLON)
                    finish_reply(rrp_pkg::K_INTEGER, '0);
                else if (prs_type == rrp_pkg::CH_MINUS)
                    finish_reply(rrp_pkg::K_ERRREPLY, '0);
                else if (prs_type == rrp_pkg::CH_DOLLAR)
                begin
                    if (prs_ovf)
                        finish_reply(rrp_pkg::K_BADLEN, '0);
                    else if (prs_neg && prs_len == 64'd1)
                        finish_reply(rrp_pkg::K_NULL, '0);
                    else if (prs_neg && prs_len > 64'd1)
                        finish_reply(rrp_pkg::K_BADLEN, '0);
                    else
                    begin
                        prs_left = prs_len + 64'd2;
                        prs_phase = PARSE_DISCARD;
                    end
                end
                else
                    finish_reply(rrp_pkg::K_BADTYPE, '0);
            end
            default:
            begin
                if (prs_left > 64'd0)
                    prs_left--;
                if (prs_left == 64'd0)
                    finish_reply(rrp_pkg::K_BULK, prs_len[rrp_pkg::BLEN_W-1:0]);
            end
        endcase
    endfunction

    // Send one byte; enter and leave at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < rx_gap_pct)
        begin
            rx_valid = 1'b0;
            @(negedge clk);
        end
        rx_valid = 1'b1;
        rx_byte = b;
        @(posedge clk);
        while (rx_stall !== 1'b0)
            @(posedge clk);
        parse_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task automatic send_crlf();
        send_byte(rrp_pkg::CH_CR);
        send_byte(rrp_pkg::CH_LF);
    endtask

    task automatic send_random_byte();
        send_byte(8'($urandom_range(0, 255)));
    endtask

    // Header bytes of any value but CR
    task automatic send_header_noise(input int n);
        logic [7:0] b;
        repeat (n)
        begin
            b = 8'($urandom_range(0, 255));
            while (b == rrp_pkg::CH_CR)
                b = 8'($urandom_range(0, 255));
            send_byte(b);
        end
    endtask

    task automatic send_blanks(input int n);
        repeat (n)
        begin
            case ($urandom_range(0, 4))
                0: send_byte(rrp_pkg::CH_SPACE);
                1: send_byte(rrp_pkg::CH_TAB);
                2: send_byte(rrp_pkg::CH_VT);
                3: send_byte(rrp_pkg::CH_FF);
                default: send_byte(rrp_pkg::CH_LF);
            endcase
        end
    endtask

    // Sometimes trail the digits with junk that starts on a non-digit
    task automatic send_tail();
        logic [7:0] b;
        if ($urandom_range(0, 3) == 0)
        begin
            b = 8'($urandom_range(0, 255));
            while (b == rrp_pkg::CH_CR ||
                   (b >= rrp_pkg::CH_ZERO && b <= rrp_pkg::CH_NINE))
                b = 8'($urandom_range(0, 255));
            send_byte(b);
            send_header_noise($urandom_range(0, 3));
        end
    endtask

    // Pause the sender until every owed reply is back
    task automatic wait_for_replies(input int extra);
        rx_valid = 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (extra) @(negedge clk);
    endtask

    // Feed filler until the shadow parser waits for a type byte again
    task automatic close_open_reply();
        while (prs_phase != PARSE_TYPE)
        begin
            case (prs_phase)
                PARSE_HEADER: send_byte(rrp_pkg::CH_CR);
                PARSE_LF:     send_byte(rrp_pkg::CH_LF);
                default:      send_random_byte();
            endcase
        end
    endtask

    task automatic send_random_bulk();
        int len;
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 24);
        send_byte(rrp_pkg::CH_DOLLAR);
        send_blanks($urandom_range(0, 2));
        case ($urandom_range(0, 5))
            0: send_byte(rrp_pkg::CH_PLUS);
            1: if (len == 0) send_byte(rrp_pkg::CH_MINUS);
            2: send_text("00");
            default: ;
        endcase
        send_text($sformatf("%0d", len));
        send_tail();
        send_crlf();
        repeat (len) send_random_byte();
        if ($urandom_range(0, 3) == 0)
        begin
            send_random_byte();
            send_random_byte();
        end
        else
            send_crlf();
    endtask

    // One reply, mostly well formed, the rest broken or noise
    task automatic send_random_reply();
        int         sel;
        logic [7:0] b;
        sel = $urandom_range(0, 99);
        if (sel < 22)
        begin
            case ($urandom_range(0, 2))
                0: send_byte(rrp_pkg::CH_PLUS);
                1: send_byte(rrp_pkg::CH_COLON);
                default: send_byte(rrp_pkg::CH_MINUS);
            endcase
            send_header_noise($urandom_range(0, 12));
            send_crlf();
        end
        else if (sel < 58)
            send_random_bulk();
        else if (sel < 62)
        begin
            send_byte(rrp_pkg::CH_DOLLAR);
            send_blanks($urandom_range(0, 2));
            send_text("-1");
            send_tail();
            send_crlf();
        end
        else if (sel < 70)
        begin
            send_byte(rrp_pkg::CH_DOLLAR);
            if ($urandom_range(0, 1) == 0)
            begin
                send_byte(rrp_pkg::CH_MINUS);
                send_text($sformatf("%0d", $urandom_range(2, 99999)));
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                    send_byte(rrp_pkg::CH_MINUS);
                send_byte(8'(rrp_pkg::CH_ZERO + $urandom_range(1, 9)));
                repeat ($urandom_range(10, 24))
                    send_byte(8'(rrp_pkg::CH_ZERO + $urandom_range(0, 9)));
            end
            send_tail();
            send_crlf();
        end
        else if (sel < 77)
        begin
            b = 8'($urandom_range(0, 255));
            while (b == rrp_pkg::CH_PLUS || b == rrp_pkg::CH_COLON ||
                   b == rrp_pkg::CH_MINUS || b == rrp_pkg::CH_DOLLAR)
                b = 8'($urandom_range(0, 255));
            send_byte(b);
            send_header_noise($urandom_range(0, 12));
            send_crlf();
        end
        else if (sel < 86)
        begin
            send_random_byte();
            send_header_noise($urandom_range(0, 8));
            send_byte(rrp_pkg::CH_CR);
            b = 8'($urandom_range(0, 255));
            while (b == rrp_pkg::CH_LF)
                b = 8'($urandom_range(0, 255));
            send_byte(b);
        end
        else if (sel < 88)
        begin
            send_random_byte();
            send_header_noise(rrp_pkg::MAX_LINE_DEF + 1);
        end
        else
        begin
            repeat ($urandom_range(1, 8)) send_random_byte();
            close_open_reply();
        end
    endtask

    task automatic test_line_replies();
        send_text("+OK");
        send_crlf();
        send_byte(rrp_pkg::CH_PLUS);
        send_crlf();
        send_text(":-9223");
        send_crlf();
        send_text("-ERR wrong");
        send_crlf();
    endtask

    task automatic test_bulk_replies();
        send_text("$0");
        send_crlf();
        send_crlf();
        send_text("$3");
        send_crlf();
        send_text("abc");
        send_crlf();
        send_text("$-0");
        send_crlf();
        send_crlf();
        send_byte(rrp_pkg::CH_DOLLAR);
        send_crlf();
        send_crlf();
        send_text("$-1");
        send_crlf();
        // Skip blanks, take a plus sign, stop at the first non-digit
        send_byte(rrp_pkg::CH_DOLLAR);
        send_byte(rrp_pkg::CH_SPACE);
        send_byte(rrp_pkg::CH_TAB);
        send_byte(rrp_pkg::CH_VT);
        send_byte(rrp_pkg::CH_FF);
        send_byte(rrp_pkg::CH_LF);
        send_text("+2x9");
        send_crlf();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_crlf();
    endtask

    task automatic test_bad_lengths();
        send_text("$-2");
        send_crlf();
        send_text("$4294967296");
        send_crlf();
        send_text("$-4294967296");
        send_crlf();
    endtask

    task automatic test_unknown_types();
        send_byte(8'h00);
        send_crlf();
        send_byte(8'hFF);
        send_byte(8'h7A);
        send_crlf();
        send_byte(rrp_pkg::CH_CR);
        send_crlf();
        send_byte(rrp_pkg::CH_LF);
        send_crlf();
        send_text("*2");
        send_crlf();
    endtask

    task automatic test_bad_line_ends();
        send_text("+OK");
        send_byte(rrp_pkg::CH_CR);
        send_byte(8'h58);
        send_text("$5");
        send_byte(rrp_pkg::CH_CR);
        send_byte(rrp_pkg::CH_CR);
        send_text("-E");
        send_byte(rrp_pkg::CH_CR);
        send_byte(8'h00);
    endtask

    task automatic test_long_headers();
        // Longest legal header
        send_byte(rrp_pkg::CH_PLUS);
        repeat (rrp_pkg::MAX_LINE_DEF) send_byte(8'h61);
        send_crlf();
        // One character too many, then a fresh reply
        send_byte(rrp_pkg::CH_COLON);
        repeat (rrp_pkg::MAX_LINE_DEF + 1) send_byte(8'h62);
        send_byte(rrp_pkg::CH_DOLLAR);
        repeat (rrp_pkg::MAX_LINE_DEF + 1) send_byte(rrp_pkg::CH_NINE);
    endtask

    task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                       input int n_bytes);
        int stop_at;
        rx_gap_pct = sender_pct;
        reply_gap_pct = receiver_pct;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
            send_random_reply();
        wait_for_replies(4);
    endtask

    initial
    begin
        rst_n = 1'b0;
        rx_valid = 1'b0;
        rx_byte = 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_line_replies();
        test_bulk_replies();
        test_bad_lengths();
        test_unknown_types();
        test_bad_line_ends();
        test_long_headers();
        wait_for_replies(4);

        test_random_traffic(35, 78, 40);
        test_random_traffic(78, 35, 40);
        test_random_traffic(0, 0, 40);

        wait_for_replies(TAIL_CYCLES);
        if (error_count == 0)
            $display("resp_reply_parser verification clean");
        else
            $display("resp_reply_parser verification failed");
        $finish;
    end

endmodule
